[src/olst_pkg.sv]
// Shared types and codes for the ordered list store.
`default_nettype none

package olst_pkg;

	// Operation codes carried by the func field of a request.
	typedef enum logic [2:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_BACK  = 3'd1,
		FN_INS_POS   = 3'd2,
		FN_POP_FRONT = 3'd3,
		FN_POP_BACK  = 3'd4,
		FN_SEARCH    = 3'd5
	} func_t;

	// Status codes returned with every result.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// What every cell does in the current cycle.
	typedef enum logic [1:0] {
		COP_HOLD      = 2'd0,
		COP_INSERT    = 2'd1,
		COP_POP_FRONT = 2'd2,
		COP_SEARCH    = 2'd3
	} cell_op_t;

	localparam int unsigned DATA_W = 32;

	// Command broadcast from the controller to the row of cells.
	typedef struct packed {
		cell_op_t           op;
		logic [DATA_W-1:0]  value;
	} cell_ctl_t;

endpackage

`default_nettype wire

[src/olst_cell.sv]
// One storage cell of the ordered list: holds one entry and shifts with its neighbors.
`default_nettype none

module olst_cell
	import olst_pkg::*;
#(
	parameter int unsigned CW    = 5,
	parameter int unsigned INDEX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire logic [CW-1:0]     ins_pos,
	input  wire logic [CW-1:0]     count,
	input  wire logic [DATA_W-1:0] left_in,
	input  wire logic [DATA_W-1:0] right_in,
	output logic      [DATA_W-1:0] entry,
	output logic                   match
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [DATA_W-1:0] entry_q;
	logic              match_q;

	// The entry is payload and is only meaningful below the fill count.
	always_ff @(posedge clk) begin
		case (ctl.op)
			COP_INSERT: begin
				if (IDX > ins_pos) begin
					entry_q <= left_in;
				end else if (IDX == ins_pos) begin
					entry_q <= ctl.value;
				end
			end
			COP_POP_FRONT: begin
				entry_q <= right_in;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= (ctl.op == COP_SEARCH) && (IDX < count) && (entry_q == ctl.value);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

`default_nettype wire

[src/ordered_list_store.sv]
// Top level of the ordered list store: request decode, fill count and the row of cells.
`default_nettype none

// The store keeps up to CAPACITY signed 32-bit values in order, front first,
// in a row of cells that shift toward the back on an insert and toward the
// front on a pop from the front. A request is taken at any rising edge where
// start is high and busy is low; busy never rises, so a new request may be
// issued in every cycle. Each request yields exactly one result, presented on
// status, found and length for one cycle with done high, in the cycle right
// after the request was taken. The receiver cannot stall, so results must be
// captured when done is high. For every operation, the cells update their
// entries and their search compares at the edge that takes the request, and
// the found flag is the OR of the registered per-cell compares.
// Length reports the number of entries held after the request. Entries are not
// cleared at reset; only entries below the fill count are ever used.
module ordered_list_store
	import olst_pkg::*;
#(
	parameter int unsigned CAPACITY = 16,
	localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [2:0]        func,
	input  wire logic signed [31:0] value,
	input  wire logic [CW-1:0]     position,
	output logic                   done,
	output logic [1:0]             status,
	output logic                   found,
	output logic [CW-1:0]          length
);

	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	logic          accept;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	status_t       status_d;
	status_t       status_q;
	logic          done_q;
	cell_ctl_t     ctl;
	logic [CW-1:0] ins_pos;
	logic          full;
	logic          empty;

	logic [DATA_W-1:0]   entry_vec [CAPACITY];
	logic [CAPACITY-1:0] match_vec;

	// The block never holds off a request, so busy is tied low.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q >= CAP);
	assign empty  = (count_q == '0);

	// Decode the request into a status, the new fill count and the cell command.
	// A full store drops inserts; for insert at a position, a position past
	// the current length is reported before a full store is.
	always_comb begin
		status_d  = ST_OK;
		count_d   = count_q;
		ins_pos   = '0;
		ctl.op    = COP_HOLD;
		ctl.value = DATA_W'(value);
		case (func)
			FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
				if (func == FN_INS_BACK) begin
					ins_pos = count_q;
				end else if (func == FN_INS_POS) begin
					ins_pos = position;
				end
				if ((func == FN_INS_POS) && (position > count_q)) begin
					status_d = ST_BADPOS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.op  = accept ? COP_INSERT : COP_HOLD;
					count_d = count_q + 1'b1;
				end
			end
			FN_POP_FRONT, FN_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					if (func == FN_POP_FRONT) begin
						ctl.op = accept ? COP_POP_FRONT : COP_HOLD;
					end
					count_d = count_q - 1'b1;
				end
			end
			FN_SEARCH: begin
				ctl.op = accept ? COP_SEARCH : COP_HOLD;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q  <= count_d;
				status_q <= status_d;
			end
		end
	end

	// The row of cells; each takes its neighbor's entry when the list shifts.
	// The front cell never shifts in from the left and the back cell may take
	// any value on a pop from the front, since it then lies past the count.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = ctl.value;
		end else begin : g_mid
			assign left_in = entry_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_in = entry_vec[i];
		end else begin : g_inner
			assign right_in = entry_vec[i+1];
		end

		olst_cell #(
			.CW    (CW),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.ins_pos  (ins_pos),
			.count    (count_q),
			.left_in  (left_in),
			.right_in (right_in),
			.entry    (entry_vec[i]),
			.match    (match_vec[i])
		);
	end

	assign done   = done_q;
	assign status = status_q;
	assign found  = |match_vec;
	assign length = count_q;

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("fill count beyond capacity");

	// Every request taken gives a result in the next cycle, and no other cycle does.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request without a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without a request");

	// A dropped insert leaves a full store, and a hit needs a held entry.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == ST_FULL)) |-> (count_q == CAP))
		else $error("full status on a store that is not full");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> ((count_q != '0) && (status_q == ST_OK)))
		else $error("search hit in an empty store");

endmodule

`default_nettype wire
